// ===== src/lwpf_pkg.sv =====
// shared types and constants for the lcd window pixel byte formatter
package lwpf_pkg;

    // request opcodes
    localparam logic [1:0] OP_WINDOW = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_POINT  = 2'd2;

    // color format codes
    localparam logic [1:0] FMT_444 = 2'd0;
    localparam logic [1:0] FMT_565 = 2'd1;
    localparam logic [1:0] FMT_666 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COLOR_FORMAT  = 2'd0;
    localparam logic [1:0] REG_COLUMN_OFFSET = 2'd1;
    localparam logic [1:0] REG_ROW_OFFSET    = 2'd2;

    // reset values of the configuration registers
    localparam logic [1:0] COLOR_FORMAT_RST  = FMT_666;
    localparam logic [7:0] COLUMN_OFFSET_RST = 8'd0;
    localparam logic [7:0] ROW_OFFSET_RST    = 8'd20;

    // panel command bytes
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    // byte slots of one job in send order
    localparam logic [3:0] IDX_CASET = 4'd0;
    localparam logic [3:0] IDX_X0_HI = 4'd1;
    localparam logic [3:0] IDX_X0_LO = 4'd2;
    localparam logic [3:0] IDX_X1_HI = 4'd3;
    localparam logic [3:0] IDX_X1_LO = 4'd4;
    localparam logic [3:0] IDX_RASET = 4'd5;
    localparam logic [3:0] IDX_Y0_HI = 4'd6;
    localparam logic [3:0] IDX_Y0_LO = 4'd7;
    localparam logic [3:0] IDX_Y1_HI = 4'd8;
    localparam logic [3:0] IDX_Y1_LO = 4'd9;
    localparam logic [3:0] IDX_RAMWR = 4'd10;
    localparam logic [3:0] IDX_PIX0  = 4'd11;
    localparam logic [3:0] IDX_PIX1  = 4'd12;
    localparam logic [3:0] IDX_PIX2  = 4'd13;

    // one drawing request
    typedef struct packed {
        logic [1:0] opcode;
        logic [8:0] x_start;
        logic [8:0] y_start;
        logic [8:0] x_end;
        logic [8:0] y_end;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lwpf_in_t;

    // one byte for the serial link
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_restart;
        logic       last;
    } lwpf_out_t;

    // classified job handed from front to back
    typedef struct packed {
        logic            has_window;
        logic [9:0]      x0;
        logic [9:0]      x1;
        logic [9:0]      y0;
        logic [9:0]      y1;
        logic [1:0]      npix;
        logic [2:0][7:0] pix;
    } lwpf_job_t;

    // back sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } lwpf_st_t;

endpackage

// ===== src/lwpf_front.sv =====
// front end: configuration registers, request classification and pixel packing
module lwpf_front import lwpf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       push,
    input  lwpf_in_t   in_item,
    input  logic       jobq_full,
    output logic       jobq_push,
    output lwpf_job_t  jobq_data
);

    logic [1:0] color_format_reg;
    logic [7:0] column_offset_reg;
    logic [7:0] row_offset_reg;
    logic       pair_pending_reg;
    logic       pair_pending_next;
    logic [3:0] held_blue_reg;
    logic [3:0] held_blue_next;
    logic       accept;
    logic       job_valid;

    assign accept = push && !jobq_full;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_format_reg  <= COLOR_FORMAT_RST;
            column_offset_reg <= COLUMN_OFFSET_RST;
            row_offset_reg    <= ROW_OFFSET_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_COLOR_FORMAT:  color_format_reg  <= cfg_wdata[1:0];
                REG_COLUMN_OFFSET: column_offset_reg <= cfg_wdata;
                REG_ROW_OFFSET:    row_offset_reg    <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // classify the request and pack its pixel bytes
    always_comb
    begin
        lwpf_job_t job;
        logic [1:0] npix;
        logic [2:0][7:0] pix;
        npix = 2'd0;
        pix  = '0;
        pair_pending_next = pair_pending_reg;
        held_blue_next    = held_blue_reg;
        job.has_window = 1'b0;
        job.x0 = {1'b0, in_item.x_start} + {2'b0, column_offset_reg};
        job.y0 = {1'b0, in_item.y_start} + {2'b0, row_offset_reg};
        job.x1 = {1'b0, in_item.x_end} + {2'b0, column_offset_reg};
        job.y1 = {1'b0, in_item.y_end} + {2'b0, row_offset_reg};

        // pixel bytes for point and 565/666 stream requests
        unique case (color_format_reg)
            FMT_444:
            begin
                npix   = 2'd2;
                pix[0] = {in_item.red[7:4], in_item.green[7:4]};
                pix[1] = {in_item.blue[7:4], 4'h0};
            end
            FMT_565:
            begin
                npix   = 2'd2;
                pix[0] = {in_item.red[7:3], in_item.green[7:5]};
                pix[1] = {in_item.green[4:2], in_item.blue[7:3]};
            end
            FMT_666:
            begin
                npix   = 2'd3;
                pix[0] = {in_item.red[7:2], 2'b00};
                pix[1] = {in_item.green[7:2], 2'b00};
                pix[2] = {in_item.blue[7:2], 2'b00};
            end
            default:
            begin
                npix = 2'd0;
            end
        endcase

        unique case (in_item.opcode)
            OP_WINDOW:
            begin
                job.has_window    = 1'b1;
                npix              = 2'd0;
                pair_pending_next = 1'b0;
            end
            OP_POINT:
            begin
                job.has_window    = 1'b1;
                job.x1            = job.x0;
                job.y1            = job.y0;
                pair_pending_next = 1'b0;
            end
            OP_PIXEL:
            begin
                // twelve-bit stream pairs two pixels into three bytes
                if (color_format_reg == FMT_444)
                begin
                    pix = '0;
                    if (!pair_pending_reg)
                    begin
                        npix              = 2'd1;
                        pix[0]            = {in_item.red[7:4], in_item.green[7:4]};
                        held_blue_next    = in_item.blue[7:4];
                        pair_pending_next = 1'b1;
                    end
                    else
                    begin
                        npix              = 2'd2;
                        pix[0]            = {held_blue_reg, in_item.red[7:4]};
                        pix[1]            = {in_item.green[7:4], in_item.blue[7:4]};
                        pair_pending_next = 1'b0;
                    end
                end
            end
            default:
            begin
                npix = 2'd0;
            end
        endcase

        job.npix  = npix;
        job.pix   = pix;
        job_valid = job.has_window || (npix != 2'd0);
        jobq_data = job;
    end

    assign jobq_push = accept && job_valid;

    // pairing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_pending_reg <= 1'b0;
            held_blue_reg    <= 4'h0;
        end
        else if (accept)
        begin
            pair_pending_reg <= pair_pending_next;
            held_blue_reg    <= held_blue_next;
        end
    end

endmodule

// ===== src/lwpf_jobq.sv =====
// small job queue between front end and byte sequencer
module lwpf_jobq import lwpf_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lwpf_job_t wr_data,
    input  logic      pop,
    output lwpf_job_t rd_data,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lwpf_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/lwpf_back.sv =====
// byte sequencer: walks one job byte by byte into the output register
module lwpf_back import lwpf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      jobq_empty,
    input  lwpf_job_t jobq_data,
    output logic      jobq_pop,
    input  logic      pop,
    output logic      empty,
    output lwpf_out_t out_item
);

    lwpf_st_t   st_reg;
    lwpf_st_t   st_next;
    logic [3:0] idx_reg;
    lwpf_job_t  job_reg;
    logic       out_valid_reg;
    lwpf_out_t  out_item_reg;
    logic       advance;
    logic       is_last;
    logic [3:0] last_idx;
    lwpf_out_t  cur_byte;

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;
    assign last_idx = (job_reg.npix == 2'd0) ? IDX_RAMWR : IDX_RAMWR + {2'b00, job_reg.npix};
    assign is_last  = (idx_reg == last_idx);

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (!jobq_empty) st_next = ST_SEND;
            ST_SEND: if (advance && is_last) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        jobq_pop = 1'b0;
        advance  = 1'b0;
        unique case (st_reg)
            ST_IDLE: jobq_pop = !jobq_empty;
            ST_SEND: advance  = !out_valid_reg || pop;
            default: ;
        endcase
    end

    // byte for the current slot
    always_comb
    begin
        cur_byte.is_data = 1'b1;
        unique case (idx_reg)
            IDX_CASET: begin cur_byte.out_byte = CMD_CASET; cur_byte.is_data = 1'b0; end
            IDX_X0_HI: cur_byte.out_byte = {6'b0, job_reg.x0[9:8]};
            IDX_X0_LO: cur_byte.out_byte = job_reg.x0[7:0];
            IDX_X1_HI: cur_byte.out_byte = {6'b0, job_reg.x1[9:8]};
            IDX_X1_LO: cur_byte.out_byte = job_reg.x1[7:0];
            IDX_RASET: begin cur_byte.out_byte = CMD_RASET; cur_byte.is_data = 1'b0; end
            IDX_Y0_HI: cur_byte.out_byte = {6'b0, job_reg.y0[9:8]};
            IDX_Y0_LO: cur_byte.out_byte = job_reg.y0[7:0];
            IDX_Y1_HI: cur_byte.out_byte = {6'b0, job_reg.y1[9:8]};
            IDX_Y1_LO: cur_byte.out_byte = job_reg.y1[7:0];
            IDX_RAMWR: begin cur_byte.out_byte = CMD_RAMWR; cur_byte.is_data = 1'b0; end
            IDX_PIX0:  cur_byte.out_byte = job_reg.pix[0];
            IDX_PIX1:  cur_byte.out_byte = job_reg.pix[1];
            IDX_PIX2:  cur_byte.out_byte = job_reg.pix[2];
            default:   cur_byte.out_byte = 8'h00;
        endcase
        cur_byte.frame_restart = !cur_byte.is_data;
        cur_byte.last          = is_last;
    end

    // state, slot counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            idx_reg       <= IDX_CASET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (jobq_pop)
            begin
                idx_reg <= jobq_data.has_window ? IDX_CASET : IDX_PIX0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        if (jobq_pop)
        begin
            job_reg <= jobq_data;
        end
        if (advance)
        begin
            out_item_reg <= cur_byte;
        end
    end

endmodule

// ===== src/lcd_window_pixel_byte_formatter.sv =====
// top level of the lcd window pixel byte formatter
// Turns drawing requests into panel bytes, at most one byte per clock on the result side. A
// window request gives 11 bytes, a point request 11 to 14, a pixel request 0 to 3. The front end
// takes one request per cycle while the job queue (JOBQ_DEPTH entries) has room; the byte
// sequencer emits one byte per cycle while its output register is free or popped, and loads
// each job while idle, taking no new job until the current one is sent. A single output
// register holds a result; within a job the next byte loads in the same cycle it is popped.
module lcd_window_pixel_byte_formatter import lwpf_pkg::*; #(
    parameter int JOBQ_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       push,
    output logic       full,
    input  lwpf_in_t   in_item,
    output logic       empty,
    input  logic       pop,
    output lwpf_out_t  out_item
);

    logic      jobq_push;
    logic      jobq_pop;
    logic      jobq_full;
    logic      jobq_empty;
    lwpf_job_t jobq_wr_data;
    lwpf_job_t jobq_rd_data;

    assign full = jobq_full;

    // request classification
    lwpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .in_item   (in_item),
        .jobq_full (jobq_full),
        .jobq_push (jobq_push),
        .jobq_data (jobq_wr_data)
    );

    // job queue
    lwpf_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (jobq_push),
        .wr_data (jobq_wr_data),
        .pop     (jobq_pop),
        .rd_data (jobq_rd_data),
        .full    (jobq_full),
        .empty   (jobq_empty)
    );

    // byte sequencer
    lwpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .jobq_empty (jobq_empty),
        .jobq_data  (jobq_rd_data),
        .jobq_pop   (jobq_pop),
        .pop        (pop),
        .empty      (empty),
        .out_item   (out_item)
    );

    // chip select restart goes with every command byte and no data byte
    a_restart_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.frame_restart == !out_item.is_data))
        else $error("frame_restart does not match command/data marking");

    // only the three window commands are ever sent as commands
    a_cmd_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.is_data) |->
            (out_item.out_byte == CMD_CASET || out_item.out_byte == CMD_RASET ||
             out_item.out_byte == CMD_RAMWR))
        else $error("unexpected command byte");

    // the queue never hands the sequencer a job without bytes
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        jobq_pop |-> (jobq_rd_data.has_window || jobq_rd_data.npix != 2'd0))
        else $error("empty job reached the byte sequencer");

endmodule
